// ===== hdl/icos_pkg.sv =====
// shared types, constants and helpers for the icosphere triangle subdivider
package icos_pkg;

    localparam int COORD_BITS = 16;
    localparam int LEVEL_BITS = 2;
    localparam int STACK_TRIS = 12;
    localparam int SP_BITS    = 4;
    localparam int EMIT_BITS  = 6;
    localparam logic signed [COORD_BITS-1:0] ONE_Q = COORD_BITS'(16384);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [2:0][COORD_BITS-1:0] t_vec;
    typedef logic [2:0][2:0][COORD_BITS-1:0] t_tri;

    typedef struct packed {
        t_coord v0_x;
        t_coord v0_y;
        t_coord v0_z;
        t_coord v1_x;
        t_coord v1_y;
        t_coord v1_z;
        t_coord v2_x;
        t_coord v2_y;
        t_coord v2_z;
    } t_in;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
        logic [EMIT_BITS-1:0] piece_index;
        logic last_piece;
    } t_out;

    typedef struct packed {
        t_tri verts;
        logic [LEVEL_BITS-1:0] lvl;
    } t_entry;

    function automatic t_coord sat_coord(input t_coord v);
        t_coord r;
        r = v;
        if (v > ONE_Q) r = ONE_Q;
        if (v < -ONE_Q) r = -ONE_Q;
        return r;
    endfunction

endpackage

// ===== hdl/icos_stack.sv =====
// triangle stack memory, one write and one registered read port
module icos_stack (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [icos_pkg::SP_BITS-1:0]  i_waddr,
    input  icos_pkg::t_entry              i_wdata,
    input  logic [icos_pkg::SP_BITS-1:0]  i_raddr,
    output icos_pkg::t_entry              o_rdata
);
    import icos_pkg::*;

    t_entry r_mem [STACK_TRIS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/icos_mid_unit.sv =====
// iterative midpoint normalizer: square sum, bit-serial square root, restoring division
module icos_mid_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  icos_pkg::t_vec  i_a,
    input  icos_pkg::t_vec  i_b,
    output logic            o_done,
    output icos_pkg::t_vec  o_m
);
    import icos_pkg::*;

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_SQ   = 5'b00010,
        U_SQRT = 5'b00100,
        U_DSET = 5'b01000,
        U_DIV  = 5'b10000
    } t_ustate;

    t_ustate r_state, n_state;
    logic signed [COORD_BITS:0] r_s [3];
    logic signed [COORD_BITS:0] n_s [3];
    logic [31:0] r_n2, n_n2;
    logic [59:0] r_rem, n_rem, r_res, n_res, r_bit, n_bit;
    logic [30:0] r_root, n_root;
    logic [31:0] r_drem, n_drem;
    logic [16:0] r_dlo, n_dlo, r_q, n_q;
    logic [4:0]  r_cnt, n_cnt;
    logic [1:0]  r_k, n_k;
    t_vec        r_m, n_m;
    logic        r_done, n_done;

    logic signed [COORD_BITS:0] s_cur, mag17;
    logic [15:0] mag;
    logic [31:0] n2_next;
    logic [59:0] sq_try, res_next;
    logic        sq_ge;
    logic [45:0] dvd;
    logic [32:0] div_sh, div_trial;
    logic        div_ge;
    logic [16:0] q_next, q_sat;
    logic [15:0] q16;

    always_comb begin
        s_cur    = r_s[r_k];
        mag17    = s_cur[COORD_BITS] ? -s_cur : s_cur;
        mag      = mag17[15:0];
        n2_next  = r_n2 + ({16'd0, mag} * {16'd0, mag});
        sq_try   = r_res + r_bit;
        sq_ge    = r_rem >= sq_try;
        res_next = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        dvd      = {1'b0, mag, 29'd0} + {15'd0, r_root};
        div_sh   = {r_drem, r_dlo[16]};
        div_trial = div_sh - {1'b0, r_root, 1'b0};
        div_ge   = div_sh >= {1'b0, r_root, 1'b0};
        q_next   = {r_q[15:0], div_ge};
        q_sat    = (q_next > 17'd16384) ? 17'd16384 : q_next;
        q16      = {1'b0, q_sat[14:0]};
    end

    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_n2    = r_n2;
        n_rem   = r_rem;
        n_res   = r_res;
        n_bit   = r_bit;
        n_root  = r_root;
        n_drem  = r_drem;
        n_dlo   = r_dlo;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_m     = r_m;
        n_done  = 1'b0;
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < 3; k++) begin
                        n_s[k] = {i_a[k][COORD_BITS-1], i_a[k]}
                               + {i_b[k][COORD_BITS-1], i_b[k]};
                    end
                    n_n2    = '0;
                    n_k     = '0;
                    n_state = U_SQ;
                end
            end
            U_SQ: begin
                n_n2 = n2_next;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_rem   = {n2_next, 28'd0};
                    n_res   = '0;
                    n_bit   = 60'd1 << 58;
                    n_state = U_SQRT;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            U_SQRT: begin
                if (sq_ge) begin
                    n_rem = r_rem - sq_try;
                end
                n_res = res_next;
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_root  = res_next[30:0];
                    n_state = U_DSET;
                end
            end
            U_DSET: begin
                if (r_root == '0) begin
                    n_m     = '0;
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end else begin
                    n_drem  = {3'd0, dvd[45:17]};
                    n_dlo   = dvd[16:0];
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = U_DIV;
                end
            end
            U_DIV: begin
                n_drem = div_ge ? div_trial[31:0] : div_sh[31:0];
                n_dlo  = {r_dlo[15:0], 1'b0};
                n_q    = q_next;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    n_m[r_k] = s_cur[COORD_BITS] ? (16'd0 - q16) : q16;
                    if (r_k == 2'd2) begin
                        n_done  = 1'b1;
                        n_state = U_IDLE;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = U_DSET;
                    end
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
        r_s    <= n_s;
        r_n2   <= n_n2;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_root <= n_root;
        r_drem <= n_drem;
        r_dlo  <= n_dlo;
        r_q    <= n_q;
        r_m    <= n_m;
    end

    assign o_done = r_done;
    assign o_m    = r_m;

endmodule

// ===== hdl/icosphere_triangle_subdivider.sv =====
// top level: stack sequencer for depth-first icosphere triangle subdivision
//
// input channel: i_in_valid / o_in_stall carry one triangle (three Q1.14
// vertices, saturated to +-1.0 on entry). output channel: o_out_valid /
// i_out_stall carry 4^levels triangles per input in depth-first order, with
// piece_index counting from 0 and last_piece set on the final one.
// levels is written through i_cfg_we / i_cfg_data; the user is to write it
// only while the block is idle; the block itself does not enforce this. one
// input is processed at a time; o_in_stall is high from the transfer until
// the last result has been taken. each split needs three midpoints from the
// shared normalizer, each computed as start, 3 square steps, 30 root steps,
// 3 x (1 setup + 17 divide) steps and done, so a split is its pop, load,
// three midpoints and four pushes; an emitted triangle waits while the
// receiver stalls. level 3 gives 21 splits and 64 emits; level 0 returns
// the input as its only piece.
// while i_out_stall is high the result holds on the output register and
// the sequencer waits. reset is synchronous and clears the sequencer and
// sets levels to 1; the stack memory is not cleared.
module icosphere_triangle_subdivider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  icos_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output icos_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [icos_pkg::LEVEL_BITS-1:0]    i_cfg_data
);
    import icos_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POP   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_MIDGO = 7'b0001000,
        S_MIDW  = 7'b0010000,
        S_PUSH  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [LEVEL_BITS-1:0] r_levels, r_lv, n_lv, r_lvl, n_lvl;
    logic [SP_BITS-1:0]    r_sp, n_sp;
    logic [EMIT_BITS-1:0]  r_emit, n_emit;
    logic [1:0]            r_k, n_k;
    t_tri                  r_vtx, n_vtx, r_m, n_m;
    t_out                  r_out, n_out;

    logic       stk_we;
    logic [SP_BITS-1:0] stk_waddr, stk_raddr;
    t_entry     stk_wdata, stk_rdata;
    logic       mid_start, mid_done;
    t_vec       mid_a, mid_b, mid_m;
    logic       in_xfer, out_xfer;
    logic [EMIT_BITS:0] total, emit_inc;
    t_tri       in_tri;

    icos_stack u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    icos_mid_unit u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mid_start),
        .i_a     (mid_a),
        .i_b     (mid_b),
        .o_done  (mid_done),
        .o_m     (mid_m)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign mid_start   = (r_state == S_MIDGO);
    assign stk_raddr   = r_sp - SP_BITS'(1);
    assign total       = (EMIT_BITS+1)'(1) << {r_lv, 1'b0};
    assign emit_inc    = {1'b0, r_emit} + (EMIT_BITS+1)'(1);

    always_comb begin
        in_tri[0][0] = sat_coord(i_in_data.v0_x);
        in_tri[0][1] = sat_coord(i_in_data.v0_y);
        in_tri[0][2] = sat_coord(i_in_data.v0_z);
        in_tri[1][0] = sat_coord(i_in_data.v1_x);
        in_tri[1][1] = sat_coord(i_in_data.v1_y);
        in_tri[1][2] = sat_coord(i_in_data.v1_z);
        in_tri[2][0] = sat_coord(i_in_data.v2_x);
        in_tri[2][1] = sat_coord(i_in_data.v2_y);
        in_tri[2][2] = sat_coord(i_in_data.v2_z);
    end

    always_comb begin
        case (r_k)
            2'd0: begin
                mid_a = r_vtx[0];
                mid_b = r_vtx[1];
            end
            2'd1: begin
                mid_a = r_vtx[1];
                mid_b = r_vtx[2];
            end
            default: begin
                mid_a = r_vtx[2];
                mid_b = r_vtx[0];
            end
        endcase
    end

    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = r_sp;
        stk_wdata.lvl = r_lvl + LEVEL_BITS'(1);
        case (r_k)
            2'd0:    stk_wdata.verts = {r_vtx[2], r_m[1], r_m[2]};
            2'd1:    stk_wdata.verts = {r_m[2], r_m[1], r_m[0]};
            2'd2:    stk_wdata.verts = {r_m[1], r_vtx[1], r_m[0]};
            default: stk_wdata.verts = {r_m[2], r_m[0], r_vtx[0]};
        endcase
        if (r_state == S_PUSH) begin
            stk_we = 1'b1;
        end else if (in_xfer) begin
            stk_we          = 1'b1;
            stk_waddr       = '0;
            stk_wdata.verts = in_tri;
            stk_wdata.lvl   = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_lv    = r_lv;
        n_lvl   = r_lvl;
        n_sp    = r_sp;
        n_emit  = r_emit;
        n_k     = r_k;
        n_vtx   = r_vtx;
        n_m     = r_m;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_sp    = SP_BITS'(1);
                    n_emit  = '0;
                    n_lv    = r_levels;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_sp    = r_sp - SP_BITS'(1);
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_vtx = stk_rdata.verts;
                n_lvl = stk_rdata.lvl;
                n_k   = '0;
                if (stk_rdata.lvl >= r_lv) begin
                    n_out.a_x = stk_rdata.verts[0][0];
                    n_out.a_y = stk_rdata.verts[0][1];
                    n_out.a_z = stk_rdata.verts[0][2];
                    n_out.b_x = stk_rdata.verts[1][0];
                    n_out.b_y = stk_rdata.verts[1][1];
                    n_out.b_z = stk_rdata.verts[1][2];
                    n_out.c_x = stk_rdata.verts[2][0];
                    n_out.c_y = stk_rdata.verts[2][1];
                    n_out.c_z = stk_rdata.verts[2][2];
                    n_out.piece_index = r_emit;
                    n_out.last_piece  = (emit_inc == total);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MIDGO;
                end
            end
            S_MIDGO: begin
                n_state = S_MIDW;
            end
            S_MIDW: begin
                if (mid_done) begin
                    n_m[r_k] = mid_m;
                    if (r_k == 2'd2) begin
                        n_k     = '0;
                        n_state = S_PUSH;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_MIDGO;
                    end
                end
            end
            S_PUSH: begin
                n_sp = r_sp + SP_BITS'(1);
                n_k  = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_POP;
                end
            end
            S_EMIT: begin
                if (out_xfer) begin
                    n_emit  = emit_inc[EMIT_BITS-1:0];
                    n_state = S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_levels <= LEVEL_BITS'(1);
            r_lv     <= '0;
            r_sp     <= '0;
            r_emit   <= '0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_levels <= i_cfg_data;
            end
            r_lv   <= n_lv;
            r_sp   <= n_sp;
            r_emit <= n_emit;
            r_k    <= n_k;
        end
        r_lvl <= n_lvl;
        r_vtx <= n_vtx;
        r_m   <= n_m;
        r_out <= n_out;
    end

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_BITS'(STACK_TRIS))
        else $error("stack pointer beyond stack depth");

    a_no_out_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("result offered while accepting input");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_piece) |-> (r_sp == '0))
        else $error("last piece with triangles still pending");

    a_piece_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_data.piece_index} < total))
        else $error("piece index beyond piece count");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_data.last_piece) |=> ##1 !o_in_stall)
        else $error("not idle after last transfer");
`endif

endmodule
